@@ rtl/dlss_pkg.sv @@
// ----------------------------------------------------------------------------
// dlss_pkg
// Types, constants and the sequencer ROM for the disk logic state sequencer.
// ----------------------------------------------------------------------------
package dlss_pkg;

    localparam int TRACK_BITS_W      = 17;
    localparam int POSITION_BITS_DEF = 17;

    localparam logic [3:0] SEQ_RESET_STATE = 4'h2;
    localparam logic [2:0] READ_PHASE      = 3'd4;

    // weak-bit LCG
    localparam logic [31:0] LCG_SEED   = 32'hDEADBEEF;
    localparam logic [31:0] LCG_MUL    = 32'd1664525;
    localparam logic [31:0] LCG_ADD    = 32'd1013904223;
    localparam logic [31:0] WEAK_LIMIT = 32'h4CCCCCCC;
    localparam logic [63:0] LCG_SEED_PROD =
        64'(LCG_SEED) * 64'(LCG_MUL) + 64'(LCG_ADD);
    // first LCG output after reset, kept ready in the candidate register
    localparam logic [31:0] LCG_FIRST = LCG_SEED_PROD[31:0];

    // latch commands (ROM low nibble); other codes hold the latch
    localparam logic [3:0] CMD_CLEAR = 4'h0;
    localparam logic [3:0] CMD_SHL0  = 4'h9;
    localparam logic [3:0] CMD_SHR   = 4'hA;
    localparam logic [3:0] CMD_LOAD  = 4'hB;
    localparam logic [3:0] CMD_SHL1  = 4'hD;

    localparam logic [7:0] SEQ_ROM [256] = '{
        8'h18,8'h18,8'h18,8'h18,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,
        8'h2D,8'h2D,8'h38,8'h38,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h28,8'h28,8'h28,8'h28,8'h28,8'h28,8'h28,8'h28,
        8'hD8,8'h38,8'h08,8'h28,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h39,8'h39,8'h39,8'h39,8'h3B,8'h3B,8'h3B,8'h3B,
        8'hD8,8'h48,8'h48,8'h48,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h48,8'h48,8'h48,8'h48,8'h48,8'h48,8'h48,8'h48,
        8'hD8,8'h58,8'hD8,8'h58,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h58,8'h58,8'h58,8'h58,8'h58,8'h58,8'h58,8'h58,
        8'hD8,8'h68,8'hD8,8'h68,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h68,8'h68,8'h68,8'h68,8'h68,8'h68,8'h68,8'h68,
        8'hD8,8'h78,8'hD8,8'h78,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h78,8'h78,8'h78,8'h78,8'h78,8'h78,8'h78,8'h78,
        8'hD8,8'h88,8'hD8,8'h88,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h08,8'h08,8'h88,8'h88,8'h08,8'h08,8'h88,8'h88,
        8'hD8,8'h98,8'hD8,8'h98,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h98,8'h98,8'h98,8'h98,8'h98,8'h98,8'h98,8'h98,
        8'hD8,8'h29,8'hD8,8'hA8,8'h0A,8'h0A,8'h0A,8'h0A,
        8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,
        8'hCD,8'hBD,8'hD8,8'hB8,8'h0A,8'h0A,8'h0A,8'h0A,
        8'hB9,8'hB9,8'hB9,8'hB9,8'hBB,8'hBB,8'hBB,8'hBB,
        8'hD9,8'h59,8'hD8,8'hC8,8'h0A,8'h0A,8'h0A,8'h0A,
        8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,
        8'hD9,8'hD9,8'hD8,8'hA0,8'h0A,8'h0A,8'h0A,8'h0A,
        8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,
        8'hD8,8'h08,8'hE8,8'hE8,8'h0A,8'h0A,8'h0A,8'h0A,
        8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,
        8'hFD,8'hFD,8'hF8,8'hF8,8'h0A,8'h0A,8'h0A,8'h0A,
        8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,
        8'hDD,8'h4D,8'hE0,8'hE0,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h88,8'h88,8'h08,8'h08,8'h88,8'h88,8'h08,8'h08
    };

    typedef struct packed {
        logic                    motor_on;
        logic                    write_mode;
        logic                    load_mode;
        logic                    raw_bit;
        logic                    track_present;
        logic                    write_protected;
        logic [TRACK_BITS_W-1:0] track_bits;
        logic                    bus_write;
        logic [7:0]              bus_value;
        logic                    consume;
    } item_t;

    typedef struct packed {
        logic [7:0]              latch_value;
        logic                    byte_ready;
        logic                    nibble_valid;
        logic                    write_enable;
        logic                    write_bit;
        logic [TRACK_BITS_W-1:0] bit_position;
        logic [3:0]              sequencer_state;
    } result_t;

endpackage

@@ rtl/disk_logic_state_sequencer.sv @@
// ----------------------------------------------------------------------------
// disk_logic_state_sequencer
// Requests are held in the input register, results in the result register.
// One request per cycle unless the result side stalls; all state updates in
// the single compute step, LCG multiply pre-computed one use ahead, reg to reg.
// Reset (async, rst_n low): state 2, phase 0, latch/bus/window/position 0,
// LCG seeded, both pipeline registers empty.
// ----------------------------------------------------------------------------
module disk_logic_state_sequencer
#(
    parameter int POSITION_BITS = dlss_pkg::POSITION_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  dlss_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output dlss_pkg::result_t result
);
    import dlss_pkg::*;

    // compare width: holds position + 1 and the full track length
    localparam int CMP_W = (POSITION_BITS + 1 > TRACK_BITS_W) ?
                           POSITION_BITS + 1 : TRACK_BITS_W;

    // ---------------- pipeline registers ----------------
    logic    s1_valid_reg;
    item_t   s1_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;

    // ---------------- sequencer state ----------------
    logic [3:0]               seq_state_reg,   seq_state_next;
    logic [2:0]               phase_reg,       phase_next;
    logic [7:0]               latch_reg,       latch_next;
    logic [7:0]               bus_byte_reg,    bus_byte_next;
    logic                     fresh_reg,       fresh_next;
    logic [3:0]               window_reg,      window_next;
    // next LCG output, computed one use ahead
    logic [31:0]              lcg_cand_reg,    lcg_cand_next;
    logic [POSITION_BITS-1:0] head_pos_reg,    head_pos_next;

    logic    out_free;
    logic    step_fire;
    result_t step_result;

    // result register frees when empty or being drained this cycle
    assign out_free   = !out_valid_reg || result_ready;
    assign step_fire  = s1_valid_reg && out_free;
    assign item_ready = !s1_valid_reg || out_free;

    assign result_valid = out_valid_reg;
    assign result       = out_result_reg;

    // ---------------- compute step ----------------
    logic                     motor;
    logic                     read_phase;
    logic [3:0]               win_shift;
    logic                     weak_hit;
    logic                     pulse;
    logic [7:0]               rom_idx;
    logic [7:0]               rom_entry;
    logic [7:0]               latch_step;
    logic                     old_msb;
    logic                     byte_rdy;
    logic                     fresh_step;
    logic                     nib_valid;
    logic                     wen;
    logic [CMP_W-1:0]         pos_inc;
    logic                     pos_wrap;
    logic [CMP_W-1:0]         pos_ext;

    always_comb
    begin
        motor      = s1_item_reg.motor_on;
        read_phase = (phase_reg == READ_PHASE);
        old_msb    = latch_reg[7];

        bus_byte_next = s1_item_reg.bus_write ? s1_item_reg.bus_value : bus_byte_reg;

        // head window: missing track reads as zero
        win_shift = {window_reg[2:0], s1_item_reg.track_present & s1_item_reg.raw_bit};
        weak_hit  = (lcg_cand_reg < WEAK_LIMIT);
        pulse     = read_phase && ((win_shift != 4'h0) ? win_shift[1] : weak_hit);

        rom_idx   = {seq_state_reg, s1_item_reg.write_mode, s1_item_reg.load_mode,
                     old_msb, ~pulse};
        rom_entry = SEQ_ROM[rom_idx];

        unique case (rom_entry[3:0])
            CMD_CLEAR: latch_step = 8'h00;
            CMD_SHL0:  latch_step = {latch_reg[6:0], 1'b0};
            CMD_SHL1:  latch_step = {latch_reg[6:0], 1'b1};
            CMD_SHR:   latch_step = {s1_item_reg.write_protected, latch_reg[7:1]};
            CMD_LOAD:  latch_step = bus_byte_next;
            default:   latch_step = latch_reg;
        endcase

        // position advance, wrapping at the track length
        pos_inc  = CMP_W'(head_pos_reg) + CMP_W'(1);
        pos_wrap = (pos_inc >= CMP_W'(s1_item_reg.track_bits));

        // defaults: motor off freezes the sequencer
        seq_state_next = seq_state_reg;
        phase_next     = phase_reg;
        latch_next     = latch_reg;
        window_next    = window_reg;
        lcg_cand_next  = lcg_cand_reg;
        head_pos_next  = head_pos_reg;
        byte_rdy       = 1'b0;
        wen            = 1'b0;

        if (motor)
        begin
            latch_next     = latch_step;
            seq_state_next = rom_entry[7:4];
            phase_next     = phase_reg + 3'd1;
            byte_rdy       = !s1_item_reg.load_mode && !s1_item_reg.write_mode &&
                             !old_msb && latch_step[7];
            if (read_phase)
            begin
                window_next = win_shift;
                if (win_shift == 4'h0)
                begin
                    lcg_cand_next = lcg_cand_reg * LCG_MUL + LCG_ADD;
                end
                wen = s1_item_reg.write_mode && s1_item_reg.track_present &&
                      !s1_item_reg.write_protected;
                if (s1_item_reg.track_bits != '0)
                begin
                    head_pos_next = pos_wrap ? '0 : pos_inc[POSITION_BITS-1:0];
                end
            end
        end

        fresh_step = fresh_reg | byte_rdy;
        nib_valid  = s1_item_reg.consume && fresh_step && latch_next[7];
        fresh_next = nib_valid ? 1'b0 : fresh_step;

        pos_ext = CMP_W'(head_pos_next);

        step_result.latch_value     = latch_next;
        step_result.byte_ready      = byte_rdy;
        step_result.nibble_valid    = nib_valid;
        step_result.write_enable    = wen;
        step_result.write_bit       = wen & latch_next[7];
        step_result.bit_position    = pos_ext[TRACK_BITS_W-1:0];
        step_result.sequencer_state = seq_state_next;
    end

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (step_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_item_reg <= item;
        end
    end

    // ---------------- state and result registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_state_reg <= SEQ_RESET_STATE;
            phase_reg     <= 3'd0;
            latch_reg     <= 8'h00;
            bus_byte_reg  <= 8'h00;
            fresh_reg     <= 1'b0;
            window_reg    <= 4'h0;
            lcg_cand_reg  <= LCG_FIRST;
            head_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step_fire)
            begin
                seq_state_reg <= seq_state_next;
                phase_reg     <= phase_next;
                latch_reg     <= latch_next;
                bus_byte_reg  <= bus_byte_next;
                fresh_reg     <= fresh_next;
                window_reg    <= window_next;
                lcg_cand_reg  <= lcg_cand_next;
                head_pos_reg  <= head_pos_next;
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            out_result_reg <= step_result;
        end
    end

`ifndef NO_ASSERTIONS
    // a stalled input register keeps its request
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg)
        else $error("input register dropped a stalled request");

    // phase counts only on motor-on steps
    a_phase_adv: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && s1_item_reg.motor_on |=> phase_reg == 3'($past(phase_reg) + 3'd1))
        else $error("clock phase did not advance");

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(step_fire && s1_item_reg.motor_on) |=> $stable(phase_reg))
        else $error("clock phase moved without a motor-on step");

    a_wbit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_result_reg.write_enable |-> !out_result_reg.write_bit)
        else $error("write bit set without write enable");

    a_ready_msb: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_result_reg.byte_ready || out_result_reg.nibble_valid)
        |-> out_result_reg.latch_value[7])
        else $error("byte ready or nibble valid with latch MSB clear");
`endif

endmodule

@@ tb/sv/dlss_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlss_checker
// Watches both channels of the disk logic state sequencer. Every accepted
// request is run through a cycle-exact predictor of the sequencer; every
// accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module dlss_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  dlss_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_ready,
    input  dlss_pkg::result_t result,
    output int                fail_count,
    output int                pending,
    output int                results_checked,
    output int                byte_ready_count,
    output int                nibble_count,
    output int                track_write_count,
    output int                weak_draws
);

    localparam int POS_W = dlss_pkg::POSITION_BITS_DEF;

    localparam logic [31:0] RNG_SEED       = 32'hDEADBEEF;
    localparam logic [31:0] RNG_MUL        = 32'd1664525;
    localparam logic [31:0] RNG_INC        = 32'd1013904223;
    localparam logic [31:0] WEAK_THRESHOLD = 32'h4CCCCCCC;

    // {state, Q7, Q6, latch MSB, no pulse} -> {next state, latch command}
    localparam logic [7:0] STEP_ROM [256] = '{
        8'h18,8'h18,8'h18,8'h18,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,
        8'h2D,8'h2D,8'h38,8'h38,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h28,8'h28,8'h28,8'h28,8'h28,8'h28,8'h28,8'h28,
        8'hD8,8'h38,8'h08,8'h28,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h39,8'h39,8'h39,8'h39,8'h3B,8'h3B,8'h3B,8'h3B,
        8'hD8,8'h48,8'h48,8'h48,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h48,8'h48,8'h48,8'h48,8'h48,8'h48,8'h48,8'h48,
        8'hD8,8'h58,8'hD8,8'h58,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h58,8'h58,8'h58,8'h58,8'h58,8'h58,8'h58,8'h58,
        8'hD8,8'h68,8'hD8,8'h68,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h68,8'h68,8'h68,8'h68,8'h68,8'h68,8'h68,8'h68,
        8'hD8,8'h78,8'hD8,8'h78,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h78,8'h78,8'h78,8'h78,8'h78,8'h78,8'h78,8'h78,
        8'hD8,8'h88,8'hD8,8'h88,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h08,8'h08,8'h88,8'h88,8'h08,8'h08,8'h88,8'h88,
        8'hD8,8'h98,8'hD8,8'h98,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h98,8'h98,8'h98,8'h98,8'h98,8'h98,8'h98,8'h98,
        8'hD8,8'h29,8'hD8,8'hA8,8'h0A,8'h0A,8'h0A,8'h0A,
        8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,
        8'hCD,8'hBD,8'hD8,8'hB8,8'h0A,8'h0A,8'h0A,8'h0A,
        8'hB9,8'hB9,8'hB9,8'hB9,8'hBB,8'hBB,8'hBB,8'hBB,
        8'hD9,8'h59,8'hD8,8'hC8,8'h0A,8'h0A,8'h0A,8'h0A,
        8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,
        8'hD9,8'hD9,8'hD8,8'hA0,8'h0A,8'h0A,8'h0A,8'h0A,
        8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,
        8'hD8,8'h08,8'hE8,8'hE8,8'h0A,8'h0A,8'h0A,8'h0A,
        8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,
        8'hFD,8'hFD,8'hF8,8'hF8,8'h0A,8'h0A,8'h0A,8'h0A,
        8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,
        8'hDD,8'h4D,8'hE0,8'hE0,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h88,8'h88,8'h08,8'h08,8'h88,8'h88,8'h08,8'h08
    };

    // predictor state
    logic [3:0]       seq;
    logic [2:0]       phase;
    logic [7:0]       latch;
    logic [7:0]       bus_byte;
    logic             fresh;
    logic [3:0]       window;
    logic [31:0]      rng;
    logic [POS_W-1:0] head_pos;

    dlss_pkg::result_t expected_results [$];
    dlss_pkg::result_t due;

    function automatic void reset_model();
        seq      = dlss_pkg::SEQ_RESET_STATE;
        phase    = '0;
        latch    = '0;
        bus_byte = '0;
        fresh    = 1'b0;
        window   = '0;
        rng      = RNG_SEED;
        head_pos = '0;
    endfunction

    // read pulse from the head window; an all-zero window falls back to weak bits
    function automatic logic read_pulse(input logic bit_in);
        window = {window[2:0], bit_in};
        if (window != 4'h0)
            return window[1];
        rng = rng * RNG_MUL + RNG_INC;
        weak_draws++;
        return rng < WEAK_THRESHOLD;
    endfunction

    function automatic dlss_pkg::result_t step_sequencer(input dlss_pkg::item_t r);
        dlss_pkg::result_t o;
        logic              pulse;
        logic              old_msb;
        logic              read_phase;
        logic [7:0]        entry;
        logic [POS_W:0]    nx;
        o = '0;
        if (r.bus_write)
            bus_byte = r.bus_value;
        if (r.motor_on)
        begin
            read_phase = (phase == dlss_pkg::READ_PHASE);
            pulse = 1'b0;
            if (read_phase)
                pulse = read_pulse(r.track_present & r.raw_bit);
            old_msb = latch[7];
            entry = STEP_ROM[{seq, r.write_mode, r.load_mode, old_msb, ~pulse}];
            case (entry[3:0])
                dlss_pkg::CMD_CLEAR: latch = '0;
                dlss_pkg::CMD_SHL0:  latch = {latch[6:0], 1'b0};
                dlss_pkg::CMD_SHR:   latch = {r.write_protected, latch[7:1]};
                dlss_pkg::CMD_LOAD:  latch = bus_byte;
                dlss_pkg::CMD_SHL1:  latch = {latch[6:0], 1'b1};
                default: ;
            endcase
            seq = entry[7:4];
            if (!r.load_mode && !r.write_mode && !old_msb && latch[7])
            begin
                fresh = 1'b1;
                o.byte_ready = 1'b1;
            end
            if (read_phase)
            begin
                if (r.write_mode && r.track_present && !r.write_protected)
                begin
                    o.write_enable = 1'b1;
                    o.write_bit    = latch[7];
                end
                if (r.track_bits != '0)
                begin
                    nx = {1'b0, head_pos} + 1'b1;
                    head_pos = (nx >= r.track_bits) ? '0 : nx[POS_W-1:0];
                end
            end
            phase = phase + 1'b1;
        end
        if (r.consume && fresh && latch[7])
        begin
            o.nibble_valid = 1'b1;
            fresh = 1'b0;
        end
        o.latch_value     = latch;
        o.bit_position    = dlss_pkg::TRACK_BITS_W'(head_pos);
        o.sequencer_state = seq;
        return o;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_model();
            expected_results.delete();
            fail_count        = 0;
            results_checked   = 0;
            byte_ready_count  = 0;
            nibble_count      = 0;
            track_write_count = 0;
            weak_draws        = 0;
        end
        else
        begin
            if (item_valid && item_ready)
                expected_results.push_back(step_sequencer(item));
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding: 0x%0h", result);
                    fail_count++;
                end
                else
                begin
                    due = expected_results.pop_front();
                    check_field("latch_value", due.latch_value, result.latch_value);
                    check_field("byte_ready", due.byte_ready, result.byte_ready);
                    check_field("nibble_valid", due.nibble_valid, result.nibble_valid);
                    check_field("write_enable", due.write_enable, result.write_enable);
                    check_field("write_bit", due.write_bit, result.write_bit);
                    check_field("bit_position", due.bit_position, result.bit_position);
                    check_field("sequencer_state", due.sequencer_state,
                                result.sequencer_state);
                    results_checked++;
                    byte_ready_count  += due.byte_ready;
                    nibble_count      += due.nibble_valid;
                    track_write_count += due.write_enable;
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

@@ tb/sv/tb_disk_logic_state_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_disk_logic_state_sequencer
// Drives sequencer-clock requests into the disk logic state sequencer and
// collects its per-clock results. A short directed pass hits motor off, every
// Q7/Q6 mode, write protect, track wrap and a missing track; random runs
// of well-formed mode sequences plus some noise follow under three idle mixes
// and one long result-side hold. Checking lives in dlss_checker.
// ----------------------------------------------------------------------------
module tb_disk_logic_state_sequencer;

    import dlss_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
    localparam int PHASE_QUOTA    = 330;   // at least this many random requests per idle mix
    localparam int DRAIN_CYCLES   = 10;    // pipeline is two deep
    localparam int ITEM_W         = $bits(item_t);

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    // knobs shared between the stimulus and the receiver process
    int   sender_idle_pct;
    int   receiver_idle_pct;
    logic stall_request;
    logic stall_done;
    int   idle_cycles = 0;

    // checker feedback
    int fail_count;
    int pending;
    int results_checked;
    int byte_ready_count;
    int nibble_count;
    int track_write_count;
    int weak_draws;

    always #(HALF_PERIOD) clk = ~clk;

    disk_logic_state_sequencer DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    dlss_checker u_check
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_ready        (item_ready),
        .item              (item),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .result            (result),
        .fail_count        (fail_count),
        .pending           (pending),
        .results_checked   (results_checked),
        .byte_ready_count  (byte_ready_count),
        .nibble_count      (nibble_count),
        .track_write_count (track_write_count),
        .weak_draws        (weak_draws)
    );

    // ------------------------------------------------------------------------
    // Request side. Inputs move on the falling edge; a request is taken at
    // the first rising edge that sees ready. Valid only drops for an idle
    // cycle, so back-to-back requests keep it high with a new payload.
    // ------------------------------------------------------------------------
    task automatic send_request(input item_t r);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= r;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    function automatic item_t make_item(input logic motor, input logic q7, input logic q6,
                                        input logic raw, input logic present,
                                        input logic wprot, input logic [16:0] tbits,
                                        input logic bus_wr, input logic [7:0] bus_val,
                                        input logic take);
        item_t r;
        r.motor_on        = motor;
        r.write_mode      = q7;
        r.load_mode       = q6;
        r.raw_bit         = raw;
        r.track_present   = present;
        r.write_protected = wprot;
        r.track_bits      = tbits;
        r.bus_write       = bus_wr;
        r.bus_value       = bus_val;
        r.consume         = take;
        return r;
    endfunction

    // One run: a stretch of sequencer clocks in a fixed Q7/Q6 mode on one
    // track, random bit stream and CPU traffic. About one run in seven is
    // plain noise so odd mixes (motor stutter, mode flips) also show up.
    task automatic send_run(inout int sent);
        item_t                       r;
        logic [ITEM_W-1:0]           noise_bits;
        int                          len;
        int                          pick;
        logic                        noise;
        logic                        no_disk;
        logic                        q7;
        logic                        q6;
        logic                        wprot;
        logic [16:0]                 tbits;
        noise   = ($urandom_range(0, 99) < 15);
        no_disk = ($urandom_range(0, 99) < 15);
        len     = $urandom_range(8, 48);
        // read-shift is the mode that produces nibbles, so favor it
        if ($urandom_range(0, 1))
            {q7, q6} = 2'b00;
        else
            {q7, q6} = 2'($urandom_range(0, 3));
        wprot = ($urandom_range(0, 3) == 0);
        pick  = $urandom_range(0, 9);
        case (pick)
            0:       tbits = '0;                          // no disk: head parks
            1, 2:    tbits = 17'($urandom_range(0, 131071));
            3:       tbits = 17'h1FFFF;
            default: tbits = 17'($urandom_range(1, 40));  // short track, wraps often
        endcase
        repeat (len)
        begin
            if (noise)
            begin
                noise_bits = ITEM_W'({$urandom, $urandom});
                r = item_t'(noise_bits);
            end
            else
            begin
                r = make_item(($urandom_range(0, 99) < 97), q7, q6,
                              1'($urandom_range(0, 1)),
                              !no_disk && ($urandom_range(0, 9) != 0),
                              wprot, tbits,
                              ($urandom_range(0, 9) == 0),
                              8'($urandom_range(0, 255)),
                              ($urandom_range(0, 2) == 0));
            end
            send_request(r);
            sent++;
        end
    endtask

    task automatic random_phase(input int sender_pct, input int receiver_pct);
        int sent;
        sender_idle_pct   = sender_pct;
        receiver_idle_pct = receiver_pct;
        sent = 0;
        while (sent < PHASE_QUOTA)
            send_run(sent);
    endtask

    // ------------------------------------------------------------------------
    // Result side. Ready is redrawn every falling edge. A stall request from
    // the stimulus makes this process hold ready low for HOLD_CYCLES while
    // requests keep coming, so the pipeline backs up into item_ready.
    // ------------------------------------------------------------------------
    initial
    begin
        result_ready = 1'b0;
        stall_done   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request && !stall_done)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                stall_done = 1'b1;
            end
            result_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Watchdog: any handshake resets the count.
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        item_valid        = 1'b0;
        item              = '0;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        stall_request     = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // motor off: bus store and consume still act, nothing clocks
        send_request(make_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 17'h0,
                               1'b1, 8'hFF, 1'b1));
        send_request(make_item(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 17'h1FFFF,
                               1'b1, 8'h00, 1'b1));
        // one full bit cell of ones in read-shift on the longest track
        repeat (8) send_request(make_item(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 17'h1FFFF,
                                          1'b0, 8'h00, 1'b1));
        // Q6 sense with write protect: shift right fills the MSB, no advance
        repeat (4) send_request(make_item(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 17'h0,
                                          1'b0, 8'h00, 1'b0));
        // write load from the bus byte; one-bit track wraps the head to 0
        repeat (4) send_request(make_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 17'h1,
                                          1'b1, 8'hA5, 1'b0));
        // write shift on a short track, consume with nothing fresh
        repeat (4) send_request(make_item(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 17'h3,
                                          1'b0, 8'h5A, 1'b1));
        // unformatted track: a missing track shifts a zero into the head window
        repeat (2) send_request(make_item(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 17'h1FFFF,
                                          1'b0, 8'h00, 1'b1));

        // long receiver hold-off lands at the start of the first random mix
        stall_request = 1'b1;
        random_phase(30, 81);
        random_phase(81, 30);
        random_phase(0, 0);

        @(negedge clk);
        item_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("Checked %0d sequencer clocks: %0d byte-ready edges, %0d nibbles consumed,",
                 results_checked, byte_ready_count, nibble_count);
        $display("%0d track writes, %0d weak-bit draws, under three idle mixes and a long hold.",
                 track_write_count, weak_draws);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
